// File: hdl/flsa_pkg.sv
// shared types and constants of the free list slot allocator
package flsa_pkg;

    // built stack depth and field widths
    localparam int POOL_DEPTH = 256;
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 9;
    localparam int OBJ_W      = 17;
    localparam int ADDR_W     = 48;
    localparam int PROD_W     = SLOT_W + OBJ_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0]  DEPTH_CNT       = CNT_W'(POOL_DEPTH);
    localparam logic [CNT_W-1:0]  RESET_CAPACITY  = CNT_W'(256);
    localparam logic [OBJ_W-1:0]  RESET_OBJ_BYTES = OBJ_W'(64);
    localparam logic [ADDR_W-1:0] RESET_BASE      = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd2;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_OVERFREE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_READ,
        ENG_ADD
    } eng_state_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [SLOT_W-1:0] index;
    } req_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] slot_address;
        status_t           status;
        logic [CNT_W-1:0]  available_count;
        logic [CNT_W-1:0]  allocated_count;
    } result_t;

endpackage

// File: hdl/flsa_front.sv
// request front end: classifies requests and queues them for the engine
module flsa_front
    import flsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              req_type,
    input  logic [SLOT_W-1:0] free_index,
    output logic              q_valid,
    output req_item_t         q_item,
    input  logic              q_pop
);

    req_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;
    req_item_t  classified;

    // classify the incoming request
    always_comb
    begin
        classified.kind  = req_type ? REQ_FREE : REQ_ALLOC;
        classified.index = free_index;
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// File: hdl/flsa_engine.sv
// allocation engine: free slot stack, counts, configuration and address math
module flsa_engine
    import flsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 q_valid,
    input  req_item_t            q_item,
    output logic                 q_pop,
    input  logic                 res_room,
    output logic                 res_push,
    output result_t              res_item
);

    eng_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    pool_capacity_reg;
    logic [OBJ_W-1:0]    object_bytes_reg;
    logic [ADDR_W-1:0]   base_address_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PROD_W-1:0]   product_reg, product_next;
    logic [SLOT_W-1:0]   mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] valid_reg;
    logic [SLOT_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic [SLOT_W-1:0]   rd_addr_reg;
    logic                rd_en;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic                cfg_hit;
    logic                start;
    logic [CNT_W-1:0]    cap_eff;
    logic [CNT_W-1:0]    count_dec;
    logic [CNT_W-1:0]    count_inc;
    logic [SLOT_W-1:0]   stack_slot;

    assign cfg_hit = cfg_write_en && (cfg_index == CFG_POOL_CAPACITY ||
                                      cfg_index == CFG_OBJECT_BYTES ||
                                      cfg_index == CFG_BASE_ADDRESS);

    // effective capacity and neighbor counts
    assign cap_eff    = (pool_capacity_reg > DEPTH_CNT) ? DEPTH_CNT : pool_capacity_reg;
    assign count_dec  = count_reg - CNT_W'(1);
    assign count_inc  = count_reg + CNT_W'(1);
    assign start      = (state_reg == ENG_IDLE) && q_valid && res_room;
    assign stack_slot = rd_valid_reg ? rd_data_reg : rd_addr_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start && q_item.kind == REQ_ALLOC && count_reg < cap_eff)
                begin
                    state_next = ENG_READ;
                end
            end
            ENG_READ: state_next = ENG_ADD;
            ENG_ADD:  state_next = ENG_IDLE;
            default:  state_next = ENG_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop        = 1'b0;
        res_push     = 1'b0;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = count_dec[SLOT_W-1:0];
        count_next   = count_reg;
        slot_next    = slot_reg;
        product_next = product_reg;
        res_item.slot_index      = '0;
        res_item.slot_address    = '0;
        res_item.status          = STAT_OK;
        res_item.available_count = cap_eff - count_reg;
        res_item.allocated_count = count_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind == REQ_ALLOC)
                    begin
                        if (count_reg < cap_eff)
                        begin
                            rd_en = 1'b1;
                        end
                        else
                        begin
                            res_push        = 1'b1;
                            res_item.status = STAT_EMPTY;
                        end
                    end
                    else
                    begin
                        res_push = 1'b1;
                        if (count_reg == '0)
                        begin
                            res_item.status = STAT_OVERFREE;
                        end
                        else
                        begin
                            mem_we                   = 1'b1;
                            count_next               = count_dec;
                            res_item.available_count = cap_eff - count_dec;
                            res_item.allocated_count = count_dec;
                        end
                    end
                end
            end
            ENG_READ:
            begin
                slot_next    = stack_slot;
                product_next = PROD_W'(stack_slot) * PROD_W'(object_bytes_reg);
            end
            ENG_ADD:
            begin
                res_push                 = 1'b1;
                count_next               = count_inc;
                res_item.slot_index      = slot_reg;
                res_item.slot_address    = base_address_reg + ADDR_W'(product_reg);
                res_item.available_count = cap_eff - count_inc;
                res_item.allocated_count = count_inc;
            end
            default:
            begin
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ENG_IDLE;
            count_reg         <= '0;
            pool_capacity_reg <= RESET_CAPACITY;
            object_bytes_reg  <= RESET_OBJ_BYTES;
            base_address_reg  <= RESET_BASE;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= cfg_hit ? '0 : count_next;
            if (cfg_write_en && cfg_index == CFG_POOL_CAPACITY)
            begin
                pool_capacity_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_write_en && cfg_index == CFG_OBJECT_BYTES)
            begin
                object_bytes_reg <= cfg_data[OBJ_W-1:0];
            end
            if (cfg_write_en && cfg_index == CFG_BASE_ADDRESS)
            begin
                base_address_reg <= cfg_data;
            end
        end
    end

    // written marks: an unwritten stack entry reads as its own position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cfg_hit)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // slot stack memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_item.index;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[count_reg[SLOT_W-1:0]];
            rd_valid_reg <= valid_reg[count_reg[SLOT_W-1:0]];
            rd_addr_reg  <= count_reg[SLOT_W-1:0];
        end
    end

    // datapath pipeline registers
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        product_reg <= product_next;
    end

endmodule

// File: hdl/flsa_result_queue.sv
// two-entry result queue toward the consumer
module flsa_result_queue
    import flsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res_item,
    output logic    res_room,
    output logic    empty,
    input  logic    pop,
    output result_t head
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign res_room = (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    // fill count update
    always_comb
    begin
        count_next = count_reg + 2'(res_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            entry_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

// File: hdl/free_list_slot_allocator.sv
// free list slot allocator: a free or flagged request is answered from the idle state and a
// good allocate goes through the read and add states before its result is queued
// the engine takes one free or flagged request per cycle while the result queue has room;
// a good allocate holds it through stack memory read, multiply and address add
// two-entry queues on both sides let input and output stall independently
// reset: stack reads slot i at position i, count zero, capacity 256, object 64 bytes, base 0
module free_list_slot_allocator
    import flsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 req_type,
    input  logic [SLOT_W-1:0]    free_index,
    output logic                 empty,
    input  logic                 pop,
    output logic [SLOT_W-1:0]    slot_index,
    output logic [ADDR_W-1:0]    slot_address,
    output logic [1:0]           status,
    output logic [CNT_W-1:0]     available_count,
    output logic [CNT_W-1:0]     allocated_count
);

    logic      q_valid;
    req_item_t q_item;
    logic      q_pop;
    logic      res_room;
    logic      res_push;
    result_t   res_item;
    result_t   head;

    // request intake
    flsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .free_index (free_index),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // stack engine
    flsa_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .res_room     (res_room),
        .res_push     (res_push),
        .res_item     (res_item)
    );

    // result delivery
    flsa_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_item (res_item),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign slot_index      = head.slot_index;
    assign slot_address    = head.slot_address;
    assign status          = head.status;
    assign available_count = head.available_count;
    assign allocated_count = head.allocated_count;

endmodule

// File: sim/free_list_slot_allocator_checker.sv
// checker for the slot allocator: tracks the free stack and compares every returned reply
`timescale 1ns / 1ps
module free_list_slot_allocator_checker
    import flsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  logic                 req_type,
    input  logic [SLOT_W-1:0]    free_index,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [SLOT_W-1:0]    slot_index,
    input  logic [ADDR_W-1:0]    slot_address,
    input  logic [1:0]           status,
    input  logic [CNT_W-1:0]     available_count,
    input  logic [CNT_W-1:0]     allocated_count,
    output int                   outstanding,
    output int                   fail_count
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the pool
    logic [SLOT_W-1:0] free_stack [POOL_DEPTH];
    logic [CNT_W-1:0]  held_count;
    logic [CNT_W-1:0]  capacity_reg;
    logic [OBJ_W-1:0]  obj_bytes_reg;
    logic [ADDR_W-1:0] base_reg;
    result_t           owed_replies [$];
    int                mismatches = 0;

    // slot i back at position i, nothing held
    function automatic void restock();
        for (int i = 0; i < POOL_DEPTH; i++)
            free_stack[i] = SLOT_W'(i);
        held_count = '0;
    endfunction

    // grant or take back one slot and build the reply the block owes
    function automatic result_t serve_request(req_kind_t kind, logic [SLOT_W-1:0] idx);
        result_t          reply;
        logic [CNT_W-1:0] limit;
        limit = (capacity_reg > DEPTH_CNT) ? DEPTH_CNT : capacity_reg;
        reply = '0;
        reply.status = STAT_OK;
        if (kind == REQ_ALLOC)
        begin
            if (held_count >= limit)
                reply.status = STAT_EMPTY;
            else
            begin
                reply.slot_index   = free_stack[held_count[SLOT_W-1:0]];
                reply.slot_address = base_reg
                                   + ADDR_W'(reply.slot_index) * ADDR_W'(obj_bytes_reg);
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
                reply.status = STAT_OVERFREE;
            else
            begin
                held_count--;
                free_stack[held_count[SLOT_W-1:0]] = idx;
            end
        end
        reply.available_count = limit - held_count;
        reply.allocated_count = held_count;
        return reply;
    endfunction

    function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        end
    endfunction

    // watch configuration, replies and requests at each edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            capacity_reg  = RESET_CAPACITY;
            obj_bytes_reg = RESET_OBJ_BYTES;
            base_reg      = RESET_BASE;
            restock();
            owed_replies.delete();
        end
        else
        begin
            // register writes refill the pool, an unlisted index does nothing
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_POOL_CAPACITY:
                    begin
                        capacity_reg = cfg_data[CNT_W-1:0];
                        restock();
                    end
                    CFG_OBJECT_BYTES:
                    begin
                        obj_bytes_reg = cfg_data[OBJ_W-1:0];
                        restock();
                    end
                    CFG_BASE_ADDRESS:
                    begin
                        base_reg = cfg_data;
                        restock();
                    end
                    default: ;
                endcase
            end

            // reply taken: compare with the oldest owed one
            if (pop && empty === 1'b0)
            begin
                if (owed_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: reply with nothing outstanding, slot 0x%0h status %0d",
                                 $time, slot_index, status);
                end
                else
                begin
                    want = owed_replies.pop_front();
                    check_field("slot_index", ADDR_W'(want.slot_index),
                                ADDR_W'(slot_index));
                    check_field("slot_address", want.slot_address, slot_address);
                    check_field("status", ADDR_W'(want.status), ADDR_W'(status));
                    check_field("available_count", ADDR_W'(want.available_count),
                                ADDR_W'(available_count));
                    check_field("allocated_count", ADDR_W'(want.allocated_count),
                                ADDR_W'(allocated_count));
                end
            end

            // request accepted
            if (push && full === 1'b0)
                owed_replies.push_back(serve_request(req_kind_t'(req_type), free_index));
        end
        outstanding <= owed_replies.size();
        fail_count  <= mismatches;
    end

endmodule

// File: sim/free_list_slot_allocator_test.sv
// testbench top: drives requests and register writes into the slot allocator, gives the verdict
`timescale 1ns / 1ps
module free_list_slot_allocator_test;
    import flsa_pkg::*;

    localparam int RANDOM_ITEMS  = 950;
    localparam int CALM_ITEMS    = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 18;

    // index past the register list
    localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 2'd3;
    localparam logic [ADDR_W-1:0]    ALL_ONES     = {ADDR_W{1'b1}};

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [ADDR_W-1:0]    cfg_data     = '0;
    logic                 push         = 1'b0;
    logic                 req_type     = 1'b0;
    logic [SLOT_W-1:0]    free_index   = '0;
    logic                 pop          = 1'b0;
    logic                 full;
    logic                 empty;
    logic [SLOT_W-1:0]    slot_index;
    logic [ADDR_W-1:0]    slot_address;
    logic [1:0]           status;
    logic [CNT_W-1:0]     available_count;
    logic [CNT_W-1:0]     allocated_count;

    int outstanding;
    int fail_count;
    int cycles    = 0;
    int sent      = 0;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit calm      = 1'b0;

    free_list_slot_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .free_index      (free_index),
        .empty           (empty),
        .pop             (pop),
        .slot_index      (slot_index),
        .slot_address    (slot_address),
        .status          (status),
        .available_count (available_count),
        .allocated_count (allocated_count)
    );

    free_list_slot_allocator_checker reply_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .free_index      (free_index),
        .empty           (empty),
        .pop             (pop),
        .slot_index      (slot_index),
        .slot_address    (slot_address),
        .status          (status),
        .available_count (available_count),
        .allocated_count (allocated_count),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // reply side: pop high except for random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0 && !calm)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (!calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(1, MAX_GAP) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // random upper bits above the register width half of the time
    function automatic logic [ADDR_W-1:0] with_junk(logic [ADDR_W-1:0] v, int w);
        logic [ADDR_W-1:0] junk;
        junk = ADDR_W'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 0)
            return v;
        return (junk << w) | v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
    endtask

    task automatic configure(logic [ADDR_W-1:0] cap, logic [ADDR_W-1:0] obj,
                             logic [ADDR_W-1:0] base);
        write_reg(CFG_POOL_CAPACITY, cap);
        write_reg(CFG_OBJECT_BYTES, obj);
        write_reg(CFG_BASE_ADDRESS, base);
        cfg_write_en <= 1'b0;
    endtask

    // hand one item over, with an optional idle burst ahead of it
    task automatic send_request(req_kind_t kind, logic [SLOT_W-1:0] idx);
        if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        push       <= 1'b1;
        req_type   <= kind;
        free_index <= idx;
        do
            @(posedge clk);
        while (full !== 1'b0);
        sent++;
    endtask

    // stop pushing and wait for every owed reply
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // one random phase: fresh registers, then a request mix
    task automatic run_phase(int count, bit fill_up);
        logic [ADDR_W-1:0] cap;
        logic [ADDR_W-1:0] obj;
        logic [ADDR_W-1:0] base;
        int                limit;
        int                alloc_pct;
        int                pace [4];
        req_kind_t         kind;
        logic [SLOT_W-1:0] idx;
        pace = '{0, 10, 30, 60};
        if (fill_up)
            cap = ADDR_W'(POOL_DEPTH);
        else
        begin
            case ($urandom_range(0, 3))
                0:       cap = ADDR_W'($urandom_range(1, 8));
                1:       cap = ADDR_W'($urandom_range(9, 64));
                2:       cap = ADDR_W'($urandom_range(256, 511));
                default: cap = ADDR_W'($urandom_range(0, 511));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       obj = ADDR_W'($urandom_range(1, 4));
            1:       obj = ($urandom_range(0, 2) == 0) ? '0 :
                           ($urandom_range(0, 1) == 0) ? ADDR_W'(65536) : ADDR_W'(17'h1FFFF);
            default: obj = ADDR_W'($urandom & 17'h1FFFF);
        endcase
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = ALL_ONES - ADDR_W'($urandom_range(0, 4095));
            default: base = ADDR_W'({$urandom, $urandom});
        endcase
        configure(with_junk(cap, CNT_W), with_junk(obj, OBJ_W), base);
        // an unlisted write now and then must leave the pool alone
        if ($urandom_range(0, 5) == 0)
        begin
            write_reg(CFG_UNLISTED, ADDR_W'({$urandom, $urandom}));
            cfg_write_en <= 1'b0;
        end
        limit     = (cap > POOL_DEPTH) ? POOL_DEPTH : int'(cap);
        alloc_pct = $urandom_range(25, 80);
        idle_pct  = pace[$urandom_range(0, 3)];
        stall_pct = pace[$urandom_range(0, 3)];
        for (int n = 0; n < count; n++)
        begin
            if (fill_up)
                kind = (n < POOL_DEPTH + 2) ? REQ_ALLOC : REQ_FREE;
            else
                kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
            if (limit > 0 && $urandom_range(0, 9) < 7)
                idx = SLOT_W'($urandom_range(0, limit - 1));
            else
                idx = SLOT_W'($urandom_range(0, 255));
            send_request(kind, idx);
        end
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct  = 20;
        stall_pct = 20;

        // reset settings: over-free first, then grants and frees, including an unchecked index
        send_request(REQ_FREE, 8'h5A);
        send_request(REQ_ALLOC, 8'hFF);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_FREE, 8'hFF);
        send_request(REQ_FREE, 8'h00);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_ALLOC, 8'h00);
        drain();

        // zero capacity
        configure('0, ADDR_W'(64), '0);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_FREE, 8'h01);
        drain();

        // capacity beyond depth, largest object size, address wrap
        configure(ADDR_W'(9'h1FF), ADDR_W'(17'h1FFFF), ALL_ONES);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_FREE, 8'hAA);
        send_request(REQ_ALLOC, 8'h00);
        drain();

        // zero object size, then an unlisted write between grants
        configure(ADDR_W'(256), '0, 48'h1234_5678_9ABC);
        send_request(REQ_ALLOC, 8'h00);
        drain();
        write_reg(CFG_UNLISTED, ALL_ONES);
        cfg_write_en <= 1'b0;
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_FREE, 8'h80);
        drain();

        // single slot pool: empty grant and over-free
        configure(ADDR_W'(1), ADDR_W'(3), ADDR_W'(100));
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_ALLOC, 8'h00);
        send_request(REQ_FREE, 8'h7F);
        send_request(REQ_FREE, 8'h7F);
        send_request(REQ_ALLOC, 8'h00);
        drain();

        // random part: one full pool run, mixed phases, then a calm tail
        sent = 0;
        run_phase(POOL_DEPTH + 14, 1'b1);
        while (sent < RANDOM_ITEMS - CALM_ITEMS)
            run_phase($urandom_range(40, 120), 1'b0);
        calm = 1'b1;
        run_phase(CALM_ITEMS, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
